// File: rtl/ppa_pkg.sv
// shared types and constants for the partitioned page allocator
`timescale 1ns / 1ps
package ppa_pkg;
  localparam int NUM_CPUS = 8;
  localparam int CPU_W = 3;
  localparam int ADDR_W = 34;
  localparam int END_W = 35;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_START = 1'b0,
    CFG_REGION_END   = 1'b1
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              cmd;
    logic [CPU_W-1:0]  cpu_id;
    logic [ADDR_W-1:0] page_addr;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [CPU_W-1:0]    partition;
  } rsp_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DONE
  } back_state_t;
endpackage

// File: rtl/ppa_front.sv
// front end: request queue, free address check and partition lookup
`timescale 1ns / 1ps
module ppa_front #(
  parameter int PAGE_BYTES = 4096,
  parameter int IDX_W = 15,
  parameter int PART_W = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  ppa_pkg::req_t              in_req,
  output logic                       in_full,
  input  logic [ppa_pkg::ADDR_W-1:0] base,
  input  logic [IDX_W:0]             total,
  input  logic [IDX_W:0]             per,
  output logic                       q_valid,
  output ppa_pkg::req_t              q_req,
  output logic                       q_bad,
  output logic [IDX_W-1:0]           q_idx,
  output logic [PART_W-1:0]          q_part,
  input  logic                       q_pop
);
  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int DEPTH = 2;

  // stage 1: register the request, its bad address flag and the raw offset
  logic                       s1_valid;
  ppa_pkg::req_t              s1_req;
  logic                       s1_bad;
  logic [ppa_pkg::ADDR_W-1:0] s1_diff;
  logic                       s2_go;
  logic                       s1_bad_c;
  logic [ppa_pkg::ADDR_W-1:0] diff_c;

  always_comb begin
    diff_c = in_req.page_addr - base;
    s1_bad_c = (in_req.page_addr[OFF_W-1:0] != '0) || (in_req.page_addr < base)
      || ({{(ppa_pkg::ADDR_W-IDX_W-1){1'b0}}, total} <= (diff_c >> OFF_W));
  end

  // queue of classified requests
  ppa_pkg::req_t     qr   [DEPTH];
  logic              qb   [DEPTH];
  logic [IDX_W-1:0]  qi   [DEPTH];
  logic [PART_W-1:0] qp   [DEPTH];
  logic              wp, rp;
  logic [1:0]        cnt;

  assign in_full = s1_valid && (cnt == 2'(DEPTH));
  assign s2_go = s1_valid && (cnt != 2'(DEPTH));

  // owner search: compare against each partition boundary, clamp to the last
  logic [IDX_W-1:0]  idx_c;
  logic [PART_W-1:0] part_c;
  always_comb begin
    idx_c = s1_diff[OFF_W +: IDX_W];
    part_c = PART_W'(ppa_pkg::NUM_CPUS - 1);
    if (per != '0) begin
      part_c = '0;
      for (int k = 1; k < ppa_pkg::NUM_CPUS; k++) begin
        if ((IDX_W+PART_W+1)'(idx_c) >= (IDX_W+PART_W+1)'(per) * (IDX_W+PART_W+1)'(k))
          part_c = PART_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (in_valid)
        s1_valid <= 1'b1;
      else if (s2_go)
        s1_valid <= 1'b0;
      if (s2_go)
        wp <= ~wp;
      if (q_pop)
        rp <= ~rp;
      cnt <= cnt + 2'(s2_go) - 2'(q_pop);
    end
    if (in_valid) begin
      s1_req <= in_req;
      s1_bad <= s1_bad_c;
      s1_diff <= diff_c;
    end
    if (s2_go) begin
      qr[wp] <= s1_req;
      qb[wp] <= s1_bad;
      qi[wp] <= idx_c;
      qp[wp] <= part_c;
    end
  end

  assign q_valid = (cnt != '0);
  assign q_req = qr[rp];
  assign q_bad = qb[rp];
  assign q_idx = qi[rp];
  assign q_part = qp[rp];
endmodule

// File: rtl/ppa_back.sv
// back end: free lists, link memory and a pop that searches from the requester's own partition
`timescale 1ns / 1ps
module ppa_back #(
  parameter int MAX_PAGES = 32768,
  parameter int PAGE_BYTES = 4096,
  parameter int IDX_W = 15,
  parameter int PART_W = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  ppa_pkg::req_t              q_req,
  input  logic                       q_bad,
  input  logic [IDX_W-1:0]           q_idx,
  input  logic [PART_W-1:0]          q_part,
  output logic                       q_pop,
  input  logic [ppa_pkg::ADDR_W-1:0] base,
  output logic                       done,
  output ppa_pkg::rsp_t              rsp
);
  localparam int OFF_W = $clog2(PAGE_BYTES);

  logic [IDX_W-1:0] link_mem [MAX_PAGES];
  logic [IDX_W-1:0] head [ppa_pkg::NUM_CPUS];
  logic [ppa_pkg::NUM_CPUS-1:0] nonempty;

  ppa_pkg::back_state_t state, state_next;
  logic [IDX_W-1:0]  rd_data;
  logic [IDX_W-1:0]  pop_h;
  logic [PART_W-1:0] pop_p;
  logic              hit;
  logic [PART_W-1:0] hit_p;
  logic [PART_W-1:0] start;

  always_comb begin
    start = PART_W'(32'(q_req.cpu_id) % ppa_pkg::NUM_CPUS);
    hit = 1'b0;
    hit_p = '0;
    for (int i = ppa_pkg::NUM_CPUS - 1; i >= 0; i--) begin
      if (nonempty[PART_W'((32'(start) + 32'(i)) % ppa_pkg::NUM_CPUS)]) begin
        hit = 1'b1;
        hit_p = PART_W'((32'(start) + 32'(i)) % ppa_pkg::NUM_CPUS);
      end
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      ppa_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_req.cmd == ppa_pkg::CMD_ALLOC && hit)
            state_next = ppa_pkg::BK_READ;
        end
      end
      ppa_pkg::BK_READ: state_next = ppa_pkg::BK_DONE;
      ppa_pkg::BK_DONE: state_next = ppa_pkg::BK_IDLE;
      default: state_next = ppa_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppa_pkg::BK_IDLE;
      nonempty <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ppa_pkg::BK_IDLE && q_valid
               && (q_req.cmd == ppa_pkg::CMD_FREE || !hit))
              || (state == ppa_pkg::BK_DONE);
      if (state == ppa_pkg::BK_IDLE && q_valid) begin
        if (q_req.cmd == ppa_pkg::CMD_FREE)
          nonempty[q_part] <= q_bad ? nonempty[q_part] : 1'b1;
      end
      if (state == ppa_pkg::BK_DONE) begin
        if (rd_data == pop_h)
          nonempty[pop_p] <= 1'b0;
      end
    end
    if (state == ppa_pkg::BK_IDLE && q_valid) begin
      if (q_req.cmd == ppa_pkg::CMD_FREE) begin
        rsp.alloc_addr <= '0;
        rsp.status <= q_bad ? ppa_pkg::ST_BAD_ADDR : ppa_pkg::ST_OK;
        rsp.partition <= q_bad ? '0 : q_part;
        if (!q_bad) begin
          link_mem[q_idx] <= nonempty[q_part] ? head[q_part] : q_idx;
          head[q_part] <= q_idx;
        end
      end else if (!hit) begin
        rsp.alloc_addr <= '0;
        rsp.status <= ppa_pkg::ST_EMPTY;
        rsp.partition <= '0;
      end else begin
        pop_h <= head[hit_p];
        pop_p <= hit_p;
      end
    end
    if (state == ppa_pkg::BK_READ)
      rd_data <= link_mem[pop_h];
    if (state == ppa_pkg::BK_DONE) begin
      if (rd_data != pop_h)
        head[pop_p] <= rd_data;
      rsp.status <= ppa_pkg::ST_OK;
      rsp.partition <= pop_p;
      rsp.alloc_addr <= base + ({{(ppa_pkg::ADDR_W-IDX_W){1'b0}}, pop_h} << OFF_W);
    end
  end
endmodule

// File: rtl/partitioned_page_allocator.sv
// top level of the partitioned page allocator
`timescale 1ns / 1ps
// Page allocator over a region split into one partition per cpu, each with a
// lifo free list linked through an on-chip link memory. A request is taken
// when start is high and busy is low; its response appears on rsp with done
// high for exactly one cycle and cannot be stalled. A front end checks free
// addresses and finds the owning partition, then queues the request; a back
// end updates the lists. A request passes the input register and the queue;
// the back end answers frees and failed allocates from its idle state, and
// successful allocates through its idle, read and done states around the
// synchronous link memory read. busy is also high for one cycle after reset
// and after each register write, while the region geometry is recomputed.
// Lists start empty after reset and are filled by issuing frees.
module partitioned_page_allocator #(
  parameter int MAX_PAGES = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  ppa_pkg::req_t               req,
  output logic                        done,
  output ppa_pkg::rsp_t               rsp,
  input  logic                        cfg_we,
  input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ppa_pkg::END_W-1:0]   cfg_data
);
  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int PART_W = 3;
  localparam int OFF_W = $clog2(PAGE_BYTES);

  // configuration registers
  logic [ppa_pkg::ADDR_W-1:0] region_start;
  logic [ppa_pkg::END_W-1:0]  region_end;
  // derived geometry, registered from the configuration registers
  logic [ppa_pkg::ADDR_W-1:0] base;
  logic [IDX_W:0]             total, per;
  logic [ppa_pkg::END_W:0]    base_up, span;
  // holds requests off while the geometry catches up with the registers
  logic                       cfg_settle;

  always_comb begin
    base_up = {2'b0, region_start} + (ppa_pkg::END_W+1)'(PAGE_BYTES - 1);
    base_up[OFF_W-1:0] = '0;
    span = {1'b0, region_end} - base_up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end <= ppa_pkg::END_W'(35'd2281701376);
    end else if (cfg_we) begin
      case (ppa_pkg::cfg_idx_t'(cfg_idx))
        ppa_pkg::CFG_REGION_START: region_start <= cfg_data[ppa_pkg::ADDR_W-1:0];
        ppa_pkg::CFG_REGION_END:   region_end <= cfg_data;
        default: ;
      endcase
    end
    base <= base_up[ppa_pkg::ADDR_W-1:0];
    // a base rounded past the address space leaves no page that can be freed
    if ({1'b0, region_end} <= base_up || base_up[ppa_pkg::ADDR_W])
      total <= '0;
    else if ((span >> OFF_W) > (ppa_pkg::END_W+1)'(MAX_PAGES))
      total <= (IDX_W+1)'(MAX_PAGES);
    else
      total <= span[OFF_W +: IDX_W+1];
    per <= total / (IDX_W+1)'(ppa_pkg::NUM_CPUS);
  end

  always_ff @(posedge clk) begin
    if (rst)
      cfg_settle <= 1'b1;
    else
      cfg_settle <= cfg_we;
  end

  logic                       q_valid, q_bad, q_pop, in_full;
  ppa_pkg::req_t              q_req;
  logic [IDX_W-1:0]           q_idx;
  logic [PART_W-1:0]          q_part;

  assign busy = in_full || cfg_settle;

  ppa_front #(.PAGE_BYTES(PAGE_BYTES), .IDX_W(IDX_W), .PART_W(PART_W)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_req(req), .in_full(in_full),
    .base(base), .total(total), .per(per), .q_valid(q_valid), .q_req(q_req),
    .q_bad(q_bad), .q_idx(q_idx), .q_part(q_part), .q_pop(q_pop)
  );

  ppa_back #(.MAX_PAGES(MAX_PAGES), .PAGE_BYTES(PAGE_BYTES),
    .IDX_W(IDX_W), .PART_W(PART_W)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_req(q_req), .q_bad(q_bad),
    .q_idx(q_idx), .q_part(q_part), .q_pop(q_pop), .base(base),
    .done(done), .rsp(rsp)
  );
endmodule
